[hdl/ridft_pkg.sv]
// Shared types and constants for the real-input direct DFT block.
// Holds the command and result word formats, the control word of the MAC unit
// and the series constants used to build the twiddle ROM. No dependencies.
package ridft_pkg;

    localparam int SAMPLE_BITS       = 16;
    localparam int TW_BITS           = 16;
    localparam int OUT_BITS          = 44;
    localparam int INDEX_BITS        = 12;
    localparam int DEF_SIGNAL_LENGTH = 1024;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_BIN   = 1'b1;

    localparam longint unsigned QUARTER_PI_Q30 = 64'd843314857;
    localparam longint unsigned ONE_Q30        = 64'd1073741824;
    localparam int              TAYLOR_TERMS   = 7;

    localparam longint unsigned SIN_DIV [TAYLOR_TERMS] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210
    };
    localparam longint unsigned COS_DIV [TAYLOR_TERMS] = '{
        64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182
    };

    typedef struct packed {
        logic                          cmd;
        logic [INDEX_BITS-1:0]         index;
        logic signed [SAMPLE_BITS-1:0] sample;
    } t_in_word;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] bin_real;
        logic signed [OUT_BITS-1:0] bin_imag;
        logic                       bin_out_of_range;
    } t_out_word;

    typedef struct packed {
        logic valid;
        logic last;
        logic clear;
    } t_mac_ctl;

endpackage

[hdl/ridft_tw_rom.sv]
// Twiddle ROM holding cos and negated sin of 2*pi*m/N in Q1.15.
// The contents are built at elaboration from fixed-point Taylor series.
// Depends on ridft_pkg.
module ridft_tw_rom #(
    parameter int SIGNAL_LENGTH = ridft_pkg::DEF_SIGNAL_LENGTH,
    parameter int AW            = 10
) (
    input  logic                                    i_clk,
    input  logic [AW-1:0]                           i_addr,
    output logic signed [ridft_pkg::TW_BITS-1:0]    o_cos,
    output logic signed [ridft_pkg::TW_BITS-1:0]    o_nsin
);
    import ridft_pkg::*;

    typedef logic [2*TW_BITS-1:0] t_tw_rom [SIGNAL_LENGTH];

    function automatic longint unsigned f_mul_q30(input longint unsigned a,
                                                  input longint unsigned b);
        return (a * b) >> 30;
    endfunction

    function automatic longint unsigned f_series(input longint unsigned first,
                                                 input longint unsigned x2,
                                                 input bit odd);
        longint unsigned t;
        longint          acc;
        t   = first;
        acc = longint'(first);
        for (int n = 0; n < TAYLOR_TERMS; n++) begin
            if (odd) begin
                t = f_mul_q30(t, x2) / SIN_DIV[n];
            end else begin
                t = f_mul_q30(t, x2) / COS_DIV[n];
            end
            if (n % 2 == 0) begin
                acc = acc - longint'(t);
            end else begin
                acc = acc + longint'(t);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        return longint'(acc);
    endfunction

    function automatic logic signed [TW_BITS-1:0] f_to_q15(input longint unsigned v);
        longint unsigned r;
        r = (v + 64'd16384) >> 15;
        if (r > 64'd32767) begin
            r = 64'd32767;
        end
        return TW_BITS'(r);
    endfunction

    function automatic t_tw_rom f_build();
        t_tw_rom                   rom;
        longint unsigned           q;
        longint unsigned           r;
        longint unsigned           x;
        longint unsigned           x2;
        longint unsigned           s;
        longint unsigned           c;
        longint unsigned           t;
        logic signed [TW_BITS-1:0] cq;
        logic signed [TW_BITS-1:0] sq;
        logic signed [TW_BITS-1:0] tc;
        logic signed [TW_BITS-1:0] ts;
        bit                        swap;
        for (int m = 0; m < SIGNAL_LENGTH; m++) begin
            q    = (4 * longint'(m)) / SIGNAL_LENGTH;
            r    = 4 * longint'(m) - q * SIGNAL_LENGTH;
            swap = (2 * r > SIGNAL_LENGTH);
            if (swap) begin
                x = (2 * (SIGNAL_LENGTH - r) * QUARTER_PI_Q30) / SIGNAL_LENGTH;
            end else begin
                x = (2 * r * QUARTER_PI_Q30) / SIGNAL_LENGTH;
            end
            x2 = f_mul_q30(x, x);
            s  = f_series(x, x2, 1'b1);
            c  = f_series(ONE_Q30, x2, 1'b0);
            if (swap) begin
                t = s;
                s = c;
                c = t;
            end
            cq = f_to_q15(c);
            sq = f_to_q15(s);
            unique case (q[1:0])
                2'd0: begin
                    tc = cq;
                    ts = sq;
                end
                2'd1: begin
                    tc = -sq;
                    ts = cq;
                end
                2'd2: begin
                    tc = -cq;
                    ts = -sq;
                end
                default: begin
                    tc = sq;
                    ts = -cq;
                end
            endcase
            rom[m] = {tc, -ts};
        end
        return rom;
    endfunction

    localparam t_tw_rom TwRom = f_build();

    logic [2*TW_BITS-1:0] r_data;

    always_ff @(posedge i_clk) begin
        r_data <= TwRom[i_addr];
    end

    assign o_cos  = r_data[2*TW_BITS-1:TW_BITS];
    assign o_nsin = r_data[TW_BITS-1:0];

endmodule

[hdl/ridft_mac.sv]
// Shared multiply-accumulate unit for the real and imaginary sums.
// A registered product stage feeds two wide accumulators. Depends on ridft_pkg.
module ridft_mac #(
    parameter int ACC_W = 45
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  ridft_pkg::t_mac_ctl                      i_ctl,
    input  logic signed [ridft_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic signed [ridft_pkg::TW_BITS-1:0]     i_cos,
    input  logic signed [ridft_pkg::TW_BITS-1:0]     i_nsin,
    output logic                                     o_done,
    output logic signed [ACC_W-1:0]                  o_re,
    output logic signed [ACC_W-1:0]                  o_im
);
    import ridft_pkg::*;

    localparam int PROD_W = SAMPLE_BITS + TW_BITS;

    logic                     r_p_v;
    logic                     r_p_last;
    logic                     r_done;
    logic signed [PROD_W-1:0] r_p_re;
    logic signed [PROD_W-1:0] r_p_im;
    logic signed [ACC_W-1:0]  r_acc_re;
    logic signed [ACC_W-1:0]  r_acc_im;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v    <= 1'b0;
            r_p_last <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_p_v    <= i_ctl.valid;
            r_p_last <= i_ctl.last;
            r_done   <= r_p_v & r_p_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_re <= i_sample * i_cos;
        r_p_im <= i_sample * i_nsin;
        if (i_ctl.clear) begin
            r_acc_re <= '0;
            r_acc_im <= '0;
        end else if (r_p_v) begin
            r_acc_re <= r_acc_re + ACC_W'(r_p_re);
            r_acc_im <= r_acc_im + ACC_W'(r_p_im);
        end
    end

    assign o_done = r_done;
    assign o_re   = r_acc_re;
    assign o_im   = r_acc_im;

endmodule

[hdl/real_input_direct_dft.sv]
// Top level of the real-input direct DFT: command sequencer and sample memory.
// Uses ridft_tw_rom for twiddles and ridft_mac for the sums. Depends on ridft_pkg.
//
//   port group          direction  handshake          word
//   i_start / i_word    in         i_start & !o_busy  cmd, index, sample
//   o_valid / o_word    out        o_valid strobe     bin_real, bin_imag, bin_out_of_range
//
// A sample write leaves o_busy low.
// A bin request walks all N samples through one shared MAC, one sample per cycle,
// and the result word appears in the same cycle that o_busy falls.
// A bin above N/2 gives its result word in the cycle after acceptance with no busy time.
// Reset is synchronous and active low; the sample memory is not cleared.
// The receiver cannot stall: each result word is shown for exactly one cycle.
module real_input_direct_dft #(
    parameter int SIGNAL_LENGTH = ridft_pkg::DEF_SIGNAL_LENGTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  ridft_pkg::t_in_word  i_word,
    output logic                 o_busy,
    output logic                 o_valid,
    output ridft_pkg::t_out_word o_word
);
    import ridft_pkg::*;

    localparam int AW      = $clog2(SIGNAL_LENGTH);
    localparam int PW      = AW + 1;
    localparam int ACC_RAW = SAMPLE_BITS + TW_BITS + AW + 1;
    localparam int AccW    = (ACC_RAW > OUT_BITS) ? ACC_RAW : OUT_BITS + 1;

    localparam logic [INDEX_BITS:0] LenIdx  = (INDEX_BITS + 1)'(SIGNAL_LENGTH);
    localparam logic [INDEX_BITS:0] HalfIdx = (INDEX_BITS + 1)'(SIGNAL_LENGTH / 2);
    localparam logic [PW-1:0]       LenPw   = PW'(SIGNAL_LENGTH);
    localparam logic [AW-1:0]       LastJ   = AW'(SIGNAL_LENGTH - 1);

    localparam logic signed [AccW-1:0] SatHi = AccW'((64'sd1 <<< (OUT_BITS - 1)) - 64'sd1);
    localparam logic signed [AccW-1:0] SatLo = -SatHi - AccW'(1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_WAIT
    } t_state;

    t_state                        r_state;
    logic                          r_valid;
    t_out_word                     r_out;
    logic [AW-1:0]                 r_j;
    logic [AW-1:0]                 r_phase;
    logic [AW-1:0]                 r_k;
    logic                          r_rd_v;
    logic                          r_rd_last;
    logic signed [SAMPLE_BITS-1:0] r_smp;
    logic signed [SAMPLE_BITS-1:0] r_mem [SIGNAL_LENGTH];

    logic                          w_we;
    logic [PW-1:0]                 n_sum;
    logic [AW-1:0]                 n_phase;
    t_mac_ctl                      w_mac_ctl;
    logic signed [TW_BITS-1:0]     w_cos;
    logic signed [TW_BITS-1:0]     w_nsin;
    logic                          w_done;
    logic signed [AccW-1:0]        w_re;
    logic signed [AccW-1:0]        w_im;

    function automatic logic signed [OUT_BITS-1:0] f_sat(input logic signed [AccW-1:0] v);
        logic signed [AccW-1:0] c;
        priority if (v > SatHi) begin
            c = SatHi;
        end else if (v < SatLo) begin
            c = SatLo;
        end else begin
            c = v;
        end
        return c[OUT_BITS-1:0];
    endfunction

    assign w_we = (r_state == S_IDLE) && i_start && (i_word.cmd == CMD_WRITE)
                  && ({1'b0, i_word.index} < LenIdx);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[i_word.index[AW-1:0]] <= i_word.sample;
        end
        r_smp <= r_mem[r_j];
    end

    always_comb begin
        n_sum = {1'b0, r_phase} + {1'b0, r_k};
        if (n_sum >= LenPw) begin
            n_phase = AW'(n_sum - LenPw);
        end else begin
            n_phase = n_sum[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= 1'b0;
            r_rd_v    <= 1'b0;
            r_rd_last <= 1'b0;
        end else begin
            r_valid   <= 1'b0;
            r_rd_v    <= 1'b0;
            r_rd_last <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start && (i_word.cmd == CMD_BIN)) begin
                        if ({1'b0, i_word.index} > HalfIdx) begin
                            r_valid                <= 1'b1;
                            r_out.bin_real         <= '0;
                            r_out.bin_imag         <= '0;
                            r_out.bin_out_of_range <= 1'b1;
                        end else begin
                            r_state <= S_RUN;
                            r_j     <= '0;
                            r_phase <= '0;
                            r_k     <= i_word.index[AW-1:0];
                        end
                    end
                end
                S_RUN: begin
                    r_rd_v    <= 1'b1;
                    r_rd_last <= (r_j == LastJ);
                    r_j       <= r_j + AW'(1);
                    r_phase   <= n_phase;
                    if (r_j == LastJ) begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (w_done) begin
                        r_valid                <= 1'b1;
                        r_out.bin_real         <= f_sat(w_re);
                        r_out.bin_imag         <= f_sat(w_im);
                        r_out.bin_out_of_range <= 1'b0;
                        r_state                <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    ridft_tw_rom #(
        .SIGNAL_LENGTH (SIGNAL_LENGTH),
        .AW            (AW)
    ) u_tw_rom (
        .i_clk  (i_clk),
        .i_addr (r_phase),
        .o_cos  (w_cos),
        .o_nsin (w_nsin)
    );

    assign w_mac_ctl.valid = r_rd_v;
    assign w_mac_ctl.last  = r_rd_last;
    assign w_mac_ctl.clear = (r_state == S_IDLE);

    ridft_mac #(
        .ACC_W (AccW)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_mac_ctl),
        .i_sample (r_smp),
        .i_cos    (w_cos),
        .i_nsin   (w_nsin),
        .o_done   (w_done),
        .o_re     (w_re),
        .o_im     (w_im)
    );

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_word  = r_out;

endmodule
